// File: rtl/core/vpya_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and arctangent table for the pitch/yaw angle unit.
// No dependencies; every other file in rtl/core imports this package.

package vpya_pkg;

	localparam int COORD_WIDTH  = 24;
	localparam int CORDIC_STEPS = 24;

	// Difference of two coordinates, one bit wider than a coordinate.
	localparam int DIFF_W      = COORD_WIDTH + 1;
	// CORDIC datapath width and the guard shift that places a difference in it.
	localparam int XY_W        = 64;
	localparam int GUARD_SHIFT = 58 - COORD_WIDTH;

	// CORDIC gain in Q24, used to prescale -dz for the pitch pass.
	localparam int          GAIN_FRAC = 24;
	localparam int          GAIN_W    = 26;
	localparam logic [GAIN_W-1:0] GAIN_Q24 = GAIN_W'(27628053);
	localparam int          ZMUL_W    = DIFF_W + 1 + GAIN_W;

	// Binary angle: a full turn is 2^ANG_W.
	localparam int          ANG_W    = 32;
	localparam logic [ANG_W-1:0] ANG_HALF = {1'b1, {(ANG_W-1){1'b0}}};
	localparam int          TAB_LEN  = 32;
	localparam int          SHIFT_W  = $clog2(TAB_LEN);

	// Degree scaling: out = (angle * 360) >> 16.
	localparam int DEG_MUL_W = 9;
	localparam int DEG_FULL  = 360;
	localparam int DEG_FRAC  = 16;
	localparam int PROD_W    = ANG_W + DEG_MUL_W;
	localparam int DEG_W     = PROD_W - DEG_FRAC;
	localparam logic [DEG_W-1:0] DEG_MAX      = DEG_W'(23592959);
	localparam logic [DEG_W-1:0] PITCH_DOWN_V = DEG_W'(90 * 65536);
	localparam logic [DEG_W-1:0] PITCH_UP_V   = DEG_W'(270 * 65536);

	// Total cycles from an accepted request to its done strobe.
	localparam int LATENCY = 2 * CORDIC_STEPS + 3;

	localparam logic [ANG_W-1:0] ATAN_TAB [TAB_LEN] = '{
		32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4,
		32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
		32'h0028BE53, 32'h00145F2E, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C,
		32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
		32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051,
		32'h00000028, 32'h00000014, 32'h0000000A, 32'h00000005,
		32'h00000002, 32'h00000001, 32'h00000000, 32'h00000000
	};

	// Data that rides along the cell row untouched by the rotation steps.
	typedef struct packed {
		logic [XY_W-1:0]  zy;    // prescaled -dz, start value of the pitch pass
		logic [ANG_W-1:0] yaw;   // yaw angle, filled in between the two passes
		logic             vert;  // dx and dy both zero
		logic             up;    // dz > 0
	} side_t;

	typedef struct packed {
		logic [XY_W-1:0]  x;
		logic [XY_W-1:0]  y;
		logic [ANG_W-1:0] ang;
		side_t            side;
	} cord_t;

endpackage

// File: rtl/core/vpya_cell.sv
`timescale 1ns / 1ps
// One CORDIC vectoring step with its output register; cells are chained in a row.
// Depends on vpya_pkg for the cord_t payload type.

module vpya_cell (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic [vpya_pkg::SHIFT_W-1:0]   shift,
	input  logic [vpya_pkg::ANG_W-1:0]     atan,
	input  logic                           feed_valid,
	input  vpya_pkg::cord_t                feed,
	output logic                           pass_valid,
	output vpya_pkg::cord_t                pass
);
	import vpya_pkg::*;

	logic [XY_W-1:0] xs;
	logic [XY_W-1:0] ys;
	cord_t           step;
	logic            valid_s1;
	cord_t           data_s1;

	always_comb begin
		xs   = $signed(feed.x) >>> shift;
		ys   = $signed(feed.y) >>> shift;
		step = feed;
		// rotate toward the x axis, direction set by the sign of y
		if (feed.y[XY_W-1]) begin
			step.x   = feed.x - ys;
			step.y   = feed.y + xs;
			step.ang = feed.ang - atan;
		end else begin
			step.x   = feed.x + ys;
			step.y   = feed.y - xs;
			step.ang = feed.ang + atan;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= feed_valid;
		end
	end

	always_ff @(posedge clk) begin
		data_s1 <= step;
	end

	assign pass_valid = valid_s1;
	assign pass       = data_s1;

endmodule

// File: rtl/core/vpya_prep.sv
`timescale 1ns / 1ps
// Front end: coordinate differences, then the start vector of the yaw pass
// and the prescaled z term of the pitch pass. Depends on vpya_pkg.

module vpya_prep (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  take,
	input  logic signed [vpya_pkg::COORD_WIDTH-1:0] src_x,
	input  logic signed [vpya_pkg::COORD_WIDTH-1:0] src_y,
	input  logic signed [vpya_pkg::COORD_WIDTH-1:0] src_z,
	input  logic signed [vpya_pkg::COORD_WIDTH-1:0] dst_x,
	input  logic signed [vpya_pkg::COORD_WIDTH-1:0] dst_y,
	input  logic signed [vpya_pkg::COORD_WIDTH-1:0] dst_z,
	output logic                                  head_valid,
	output vpya_pkg::cord_t                       head
);
	import vpya_pkg::*;

	logic                     valid_s1;
	logic signed [DIFF_W-1:0] dx_s1;
	logic signed [DIFF_W-1:0] dy_s1;
	logic signed [DIFF_W-1:0] dz_s1;

	logic signed [XY_W-1:0]   dx_ext;
	logic signed [XY_W-1:0]   dy_ext;
	logic signed [DIFF_W:0]   negz;
	logic signed [GAIN_W-1:0] gain;
	logic signed [ZMUL_W-1:0] zprod;
	cord_t                    start_v;

	logic                     valid_s2;
	cord_t                    data_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= take;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		dx_s1 <= DIFF_W'(dst_x) - DIFF_W'(src_x);
		dy_s1 <= DIFF_W'(dst_y) - DIFF_W'(src_y);
		dz_s1 <= DIFF_W'(dst_z) - DIFF_W'(src_z);
	end

	always_comb begin
		dx_ext = XY_W'(dx_s1) <<< GUARD_SHIFT;
		dy_ext = XY_W'(dy_s1) <<< GUARD_SHIFT;
		negz   = -((DIFF_W + 1)'(dz_s1));
		gain   = $signed(GAIN_Q24);
		zprod  = ZMUL_W'(negz) * ZMUL_W'(gain);

		start_v.side.zy   = XY_W'(zprod) <<< (GUARD_SHIFT - GAIN_FRAC);
		start_v.side.yaw  = '0;
		start_v.side.vert = (dx_s1 == '0) && (dy_s1 == '0);
		start_v.side.up   = (dz_s1 > 0);
		// left half plane: mirror through the origin and start at half a turn
		if (dx_s1[DIFF_W-1]) begin
			start_v.x   = -dx_ext;
			start_v.y   = -dy_ext;
			start_v.ang = ANG_HALF;
		end else begin
			start_v.x   = dx_ext;
			start_v.y   = dy_ext;
			start_v.ang = '0;
		end
	end

	always_ff @(posedge clk) begin
		data_s2 <= start_v;
	end

	assign head_valid = valid_s2;
	assign head       = data_s2;

endmodule

// File: rtl/core/vector_to_pitch_yaw_angles_unit.sv
`timescale 1ns / 1ps
// Top level: front end, a row of 2*CORDIC_STEPS vectoring cells, degree scaling.
// Depends on vpya_pkg, vpya_prep and vpya_cell.

// Pitch and yaw of the vector from (src_x, src_y, src_z) to (dst_x, dst_y, dst_z).
// A request is taken on every clock edge where start is high; busy is always
// low, so a new request may follow in every cycle. Each request yields one
// result, shown on pitch_deg and yaw_deg for exactly one cycle while done is
// high, in request order. The receiver cannot stall the result.
// A request passes the front-end difference and start-vector registers, one
// cell per CORDIC step for yaw and again for pitch, and the degree-scaling
// output register.
// Angles are in 1/65536 degree, wrapped to [0, 360).

module vector_to_pitch_yaw_angles_unit (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    start,
	output logic                                    busy,
	input  logic signed [vpya_pkg::COORD_WIDTH-1:0] src_x,
	input  logic signed [vpya_pkg::COORD_WIDTH-1:0] src_y,
	input  logic signed [vpya_pkg::COORD_WIDTH-1:0] src_z,
	input  logic signed [vpya_pkg::COORD_WIDTH-1:0] dst_x,
	input  logic signed [vpya_pkg::COORD_WIDTH-1:0] dst_y,
	input  logic signed [vpya_pkg::COORD_WIDTH-1:0] dst_z,
	output logic                                    done,
	output logic [vpya_pkg::DEG_W-1:0]              pitch_deg,
	output logic [vpya_pkg::DEG_W-1:0]              yaw_deg
);
	import vpya_pkg::*;

	localparam int CELLS = 2 * CORDIC_STEPS;

	logic  head_valid;
	cord_t head;
	logic  feed_valid [CELLS];
	cord_t feed       [CELLS];
	logic  pass_valid [CELLS];
	cord_t pass       [CELLS];
	cord_t joint;

	logic [PROD_W-1:0] pitch_prod;
	logic [PROD_W-1:0] yaw_prod;
	logic [DEG_W-1:0]  pitch_next;
	logic [DEG_W-1:0]  yaw_next;

	logic              done_q;
	logic [DEG_W-1:0]  pitch_q;
	logic [DEG_W-1:0]  yaw_q;

	assign busy = 1'b0;

	vpya_prep u_prep (
		.clk        (clk),
		.arst_n     (arst_n),
		.take       (start & ~busy),
		.src_x      (src_x),
		.src_y      (src_y),
		.src_z      (src_z),
		.dst_x      (dst_x),
		.dst_y      (dst_y),
		.dst_z      (dst_z),
		.head_valid (head_valid),
		.head       (head)
	);

	// Hand the yaw result to the pitch pass: keep x, load the z term, park yaw.
	always_comb begin
		joint          = pass[CORDIC_STEPS-1];
		joint.y        = pass[CORDIC_STEPS-1].side.zy;
		joint.ang      = '0;
		joint.side.yaw = pass[CORDIC_STEPS-1].ang;
	end

	for (genvar k = 0; k < CELLS; k++) begin : g_cell
		if (k == 0) begin : g_first
			assign feed_valid[k] = head_valid;
			assign feed[k]       = head;
		end else if (k == CORDIC_STEPS) begin : g_joint
			assign feed_valid[k] = pass_valid[k-1];
			assign feed[k]       = joint;
		end else begin : g_link
			assign feed_valid[k] = pass_valid[k-1];
			assign feed[k]       = pass[k-1];
		end

		vpya_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.shift      (SHIFT_W'(k % CORDIC_STEPS)),
			.atan       (ATAN_TAB[k % CORDIC_STEPS]),
			.feed_valid (feed_valid[k]),
			.feed       (feed[k]),
			.pass_valid (pass_valid[k]),
			.pass       (pass[k])
		);
	end

	always_comb begin
		pitch_prod = PROD_W'(pass[CELLS-1].ang) * PROD_W'(DEG_FULL);
		yaw_prod   = PROD_W'(pass[CELLS-1].side.yaw) * PROD_W'(DEG_FULL);
		// straight up or down: fixed pitch, yaw forced to zero
		if (pass[CELLS-1].side.vert) begin
			pitch_next = pass[CELLS-1].side.up ? PITCH_UP_V : PITCH_DOWN_V;
			yaw_next   = '0;
		end else begin
			pitch_next = pitch_prod[PROD_W-1:DEG_FRAC];
			yaw_next   = yaw_prod[PROD_W-1:DEG_FRAC];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= pass_valid[CELLS-1];
		end
	end

	always_ff @(posedge clk) begin
		pitch_q <= pitch_next;
		yaw_q   <= yaw_next;
	end

	assign done      = done_q;
	assign pitch_deg = pitch_q;
	assign yaw_deg   = yaw_q;

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##LATENCY done)
		else $error("request did not produce a result after the pipeline latency");

	a_no_orphan: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, LATENCY))
		else $error("result strobe without a matching request");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (pitch_deg <= DEG_MAX) && (yaw_deg <= DEG_MAX))
		else $error("angle outside the 0..360 degree code range");

	a_vert_yaw: assert property (@(posedge clk) disable iff (!arst_n)
		pass_valid[CELLS-1] && pass[CELLS-1].side.vert |=> (yaw_deg == '0))
		else $error("vertical vector gave a nonzero yaw");

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for vector_to_pitch_yaw_angles_unit: a scoreboard class predicts
// pitch and yaw for every accepted request and compares each done strobe in order.
// Depends on vpya_pkg and the RTL under rtl/core.

module tb_top;

	import vpya_pkg::*;

	typedef logic signed [COORD_WIDTH-1:0] coord_t;

	typedef struct {
		coord_t src_x;
		coord_t src_y;
		coord_t src_z;
		coord_t dst_x;
		coord_t dst_y;
		coord_t dst_z;
	} points_t;

	typedef struct {
		logic [DEG_W-1:0] pitch;
		logic [DEG_W-1:0] yaw;
	} angles_t;

	localparam coord_t C_MAX       = {1'b0, {(COORD_WIDTH-1){1'b1}}};
	localparam coord_t C_MIN       = {1'b1, {(COORD_WIDTH-1){1'b0}}};
	localparam int     N_RANDOM    = 500;
	localparam int     CYCLE_LIMIT = 60000;

	class angle_scoreboard;
		angles_t expected_angles[$];
		int      error_count = 0;

		task report_mismatch(input string msg);
			$display("MISMATCH at %0t: %s", $realtime, msg);
			error_count++;
		endtask

		// CORDIC vectoring: rotate (x, y) onto the x axis, return the accumulated angle.
		function logic [ANG_W-1:0] cordic_vectoring(inout logic [XY_W-1:0] x,
			input logic [XY_W-1:0] y, input logic [ANG_W-1:0] ang);
			logic [XY_W-1:0] xs;
			logic [XY_W-1:0] ys;
			for (int i = 0; i < CORDIC_STEPS && i < TAB_LEN; i++) begin
				xs = $signed(x) >>> i;
				ys = $signed(y) >>> i;
				if (y[XY_W-1]) begin
					x   = x - ys;
					y   = y + xs;
					ang = ang - ATAN_TAB[i];
				end else begin
					x   = x + ys;
					y   = y - xs;
					ang = ang + ATAN_TAB[i];
				end
			end
			return ang;
		endfunction

		function logic [DEG_W-1:0] to_degrees(input logic [ANG_W-1:0] ang);
			logic [63:0] prod;
			prod = {32'b0, ang} * 64'd360;
			return prod[DEG_FRAC +: DEG_W];
		endfunction

		function angles_t predict_angles(input points_t p);
			longint          d_x;
			longint          d_y;
			longint          d_z;
			logic [XY_W-1:0] x;
			logic [XY_W-1:0] y;
			logic [XY_W-1:0] zy;
			logic [ANG_W-1:0] yaw;
			logic [ANG_W-1:0] pitch;
			angles_t         a;
			d_x = longint'(p.dst_x) - longint'(p.src_x);
			d_y = longint'(p.dst_y) - longint'(p.src_y);
			d_z = longint'(p.dst_z) - longint'(p.src_z);
			// straight up or down: no horizontal direction to measure
			if (d_x == 0 && d_y == 0) begin
				a.pitch = (d_z > 0) ? PITCH_UP_V : PITCH_DOWN_V;
				a.yaw   = '0;
				return a;
			end
			x = d_x << GUARD_SHIFT;
			y = d_y << GUARD_SHIFT;
			// fold the left half plane over, starting from half a turn
			if (d_x < 0) begin
				x   = -x;
				y   = -y;
				yaw = cordic_vectoring(x, y, ANG_HALF);
			end else begin
				yaw = cordic_vectoring(x, y, '0);
			end
			zy    = (-d_z * longint'(GAIN_Q24)) << (GUARD_SHIFT - GAIN_FRAC);
			pitch = cordic_vectoring(x, zy, '0);
			a.pitch = to_degrees(pitch);
			a.yaw   = to_degrees(yaw);
			return a;
		endfunction

		task note_request(input points_t p);
			expected_angles.push_back(predict_angles(p));
		endtask

		task check_result(input logic [DEG_W-1:0] pitch, input logic [DEG_W-1:0] yaw);
			angles_t e;
			if (expected_angles.size() == 0) begin
				report_mismatch($sformatf("unexpected result pitch %0d yaw %0d", pitch, yaw));
			end else begin
				e = expected_angles.pop_front();
				if (pitch !== e.pitch)
					report_mismatch($sformatf("pitch_deg got %0d expected %0d", pitch, e.pitch));
				if (yaw !== e.yaw)
					report_mismatch($sformatf("yaw_deg got %0d expected %0d", yaw, e.yaw));
			end
		endtask

		function int pending();
			return expected_angles.size();
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n = 1'b0;
	logic                 start  = 1'b0;
	logic                 busy;
	coord_t               src_x  = '0;
	coord_t               src_y  = '0;
	coord_t               src_z  = '0;
	coord_t               dst_x  = '0;
	coord_t               dst_y  = '0;
	coord_t               dst_z  = '0;
	logic                 done;
	logic [DEG_W-1:0]     pitch_deg;
	logic [DEG_W-1:0]     yaw_deg;

	angle_scoreboard sb = new();
	int              cycle_count = 0;
	int              burst_left  = 0;

	vector_to_pitch_yaw_angles_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.src_x     (src_x),
		.src_y     (src_y),
		.src_z     (src_z),
		.dst_x     (dst_x),
		.dst_y     (dst_y),
		.dst_z     (dst_z),
		.done      (done),
		.pitch_deg (pitch_deg),
		.yaw_deg   (yaw_deg)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// Sample pre-edge values: a request is taken when start is high and busy low.
	always @(posedge clk) begin
		points_t p;
		if (arst_n) begin
			if (start && !busy) begin
				p.src_x = src_x;
				p.src_y = src_y;
				p.src_z = src_z;
				p.dst_x = dst_x;
				p.dst_y = dst_y;
				p.dst_z = dst_z;
				sb.note_request(p);
			end
			if (done)
				sb.check_result(pitch_deg, yaw_deg);
		end
	end

	function automatic int draw_gap();
		if (burst_left > 0) begin
			burst_left--;
			return 0;
		end
		if ($urandom_range(0, 19) == 0)
			burst_left = $urandom_range(10, 40);
		return $urandom_range(0, 8);
	endfunction

	// Hold start low for the gap, then present the request until it is taken.
	task automatic send_request(input coord_t sx, input coord_t sy, input coord_t sz,
		input coord_t dx, input coord_t dy, input coord_t dz);
		int gap;
		gap = draw_gap();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		src_x <= sx;
		src_y <= sy;
		src_z <= sz;
		dst_x <= dx;
		dst_y <= dy;
		dst_z <= dz;
		do @(posedge clk); while (busy);
	endtask

	// Request a difference vector with the source at the origin.
	task automatic send_delta(input coord_t dx, input coord_t dy, input coord_t dz);
		send_request('0, '0, '0, dx, dy, dz);
	endtask

	function automatic coord_t rand_coord();
		return coord_t'($urandom);
	endfunction

	function automatic coord_t near_coord(input coord_t base);
		int off;
		off = int'($urandom_range(0, 510)) - 255;
		return coord_t'(int'(base) + off);
	endfunction

	function automatic coord_t pick_extreme();
		case ($urandom_range(0, 4))
			0: return C_MIN;
			1: return C_MAX;
			2: return coord_t'(0);
			3: return coord_t'(-1);
			default: return coord_t'(1);
		endcase
	endfunction

	initial begin
		points_t s;
		points_t d;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// vertical vectors, including the zero vector
		send_delta(0, 0, 0);
		send_delta(0, 0, 1);
		send_delta(0, 0, -1);
		send_request(0, 0, C_MIN, 0, 0, C_MAX);
		send_request(0, 0, C_MAX, 0, 0, C_MIN);
		// largest differences in both directions
		send_request(C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX);
		send_request(C_MAX, C_MAX, C_MAX, C_MIN, C_MIN, C_MIN);
		// axes and diagonals of the first three quadrants
		send_delta(1, 0, 0);
		send_delta(0, 1, 0);
		send_delta(-1, 0, 0);
		send_delta(0, -1, 0);
		send_delta(-1, 1, 0);
		send_delta(-1, -1, 0);
		send_delta(1, 1, 1);
		// angles below zero wrap to below a full turn; a pitch just above zero
		send_delta(1, -1, 0);
		send_request(C_MIN, 0, 0, C_MAX, -1, 0);
		send_request(C_MIN, 0, C_MAX, C_MAX, 0, coord_t'(C_MAX - 1));
		// steep pitch both ways with a tiny horizontal part, then a shallow one
		send_request(0, 0, C_MIN, 1, 0, C_MAX);
		send_request(0, 0, C_MAX, 0, -1, C_MIN);
		send_delta(C_MIN, C_MAX, 5);

		for (int n = 0; n < N_RANDOM; n++) begin
			s.src_x = rand_coord();
			s.src_y = rand_coord();
			s.src_z = rand_coord();
			d.dst_x = rand_coord();
			d.dst_y = rand_coord();
			d.dst_z = rand_coord();
			case ($urandom_range(0, 9))
				5, 6: begin
					d.dst_x = near_coord(s.src_x);
					d.dst_y = near_coord(s.src_y);
					d.dst_z = near_coord(s.src_z);
				end
				7: begin
					d.dst_x = s.src_x;
					d.dst_y = s.src_y;
					if ($urandom_range(0, 3) == 0)
						d.dst_z = s.src_z;
				end
				8: begin
					if ($urandom_range(0, 1))
						d.dst_x = s.src_x;
					else
						d.dst_y = s.src_y;
				end
				9: begin
					s.src_x = pick_extreme();
					s.src_y = pick_extreme();
					s.src_z = pick_extreme();
					d.dst_x = pick_extreme();
					d.dst_y = pick_extreme();
					d.dst_z = pick_extreme();
				end
				default: ;
			endcase
			send_request(s.src_x, s.src_y, s.src_z, d.dst_x, d.dst_y, d.dst_z);
		end
		start <= 1'b0;

		while (sb.pending() != 0) @(posedge clk);
		// catch any stray strobe after the last result
		repeat (LATENCY + 8) @(posedge clk);
		if (sb.error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
